// ===== design/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants of the indexed min-heap unit
// Request codes, status codes and default sizes.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_KEY_WIDTH = 32;
    localparam int ID_W          = 8;
    localparam int ID_COUNT      = 256;
    localparam int OUT_KEY_W     = 32;
    localparam int CNT_OUT_W     = 9;

    localparam logic [1:0] REQ_UPSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== design/indexed_min_heap_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_unit: indexed binary min-heap priority queue
// Sequencer that runs upsert, remove, pop and query over two memories.
// ----------------------------------------------------------------------------
// After reset the unit clears every entry of its position map and accepts
// no item meanwhile. Each request is then handled one at a time by a
// sequencer around the slot memory and the position map, each with one write
// port and one registered read port. A query or remove of an absent id, a
// pop of an empty heap or an insert into a full heap goes straight to reading
// the top slot; a query of a present id first reads its slot. A remove or pop
// moves the last entry into the vacated slot and an upsert writes its slot;
// both then usually sift, moving the entry up or down a level at a time, and
// the top slot is read last. A sift of a full 256-entry heap walks at most 8
// levels. The unit is ready again as soon as a result is registered; the
// result waits in an output register, and a later result is held in the
// sequencer until that register has been emptied.
module indexed_min_heap_unit
    import imh_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_req_type,
    input  logic [ID_W-1:0]      i_item_id,
    input  logic [31:0]          i_item_key,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_result_key,
    output logic [ID_W-1:0]      o_result_id,
    output logic [31:0]          o_top_key,
    output logic                 o_is_present,
    output logic [8:0]           o_entry_count,
    output logic [1:0]           o_status
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int POS_W  = $clog2(CAPACITY + 1);
    localparam logic [POS_W-1:0] ABSENT = POS_W'(CAPACITY);

    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_PRD    = 17'h00004,  // position read issued
        S_DEC    = 17'h00008,  // position known, decide
        S_RDX    = 17'h00010,  // read target slot
        S_RDL    = 17'h00020,  // read last slot
        S_MOVE   = 17'h00040,  // last slot data known, move it
        S_SIFT   = 17'h00080,  // read current slot
        S_SP     = 17'h00100,  // read parent
        S_SPC    = 17'h00200,  // compare parent
        S_SL     = 17'h00400,  // read left child
        S_SR     = 17'h00800,  // read right child
        S_SCC    = 17'h01000,  // compare children
        S_SWP    = 17'h02000,  // swap write 2 and map
        S_SWM    = 17'h04000,  // swap map 2
        S_TOP    = 17'h08000,  // read top slot
        S_OUT    = 17'h10000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]           r_req;
    logic [ID_W-1:0]      r_id;
    logic [KEY_WIDTH-1:0] r_key;
    logic [POS_W-1:0]     r_size;
    logic [SLOT_W-1:0]    r_t;      // current sift slot
    logic [KEY_WIDTH-1:0] r_tkey;
    logic [ID_W-1:0]      r_tid;
    logic [SLOT_W-1:0]    r_c;      // candidate slot to swap with
    logic [KEY_WIDTH-1:0] r_ckey;
    logic [ID_W-1:0]      r_cid;
    logic [ID_W-1:0]      r_clr;
    logic                 r_present;
    logic [31:0]          r_res_key;
    logic [ID_W-1:0]      r_res_id;
    logic                 r_id_set;
    logic [1:0]           r_status;
    logic                 r_rd_wait;

    logic [31:0]          r_o_rkey, r_o_tkey;
    logic [ID_W-1:0]      r_o_rid;
    logic                 r_o_pres;
    logic [8:0]           r_o_cnt;
    logic [1:0]           r_o_st;
    logic                 r_o_valid;

    // memory ports
    logic                 hm_we;
    logic [SLOT_W-1:0]    hm_waddr, hm_raddr;
    logic [KEY_WIDTH-1:0] hm_wkey, hm_rkey;
    logic [ID_W-1:0]      hm_wid, hm_rid;
    logic                 pm_we;
    logic [ID_W-1:0]      pm_waddr, pm_raddr;
    logic [POS_W-1:0]     pm_wdata, pm_rdata;

    imh_heap_mem #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .SLOT_W(SLOT_W)) u_heap (
        .i_clk(i_clk), .i_we(hm_we), .i_waddr(hm_waddr), .i_wkey(hm_wkey),
        .i_wid(hm_wid), .i_raddr(hm_raddr), .o_rkey(hm_rkey), .o_rid(hm_rid)
    );

    imh_pos_mem #(.POS_W(POS_W)) u_pos (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(pm_wdata),
        .i_raddr(pm_raddr), .o_rdata(pm_rdata)
    );

    logic [POS_W:0]  t_ext, l_ext, r_ext;
    logic            has_l, has_r, has_p;
    logic [SLOT_W-1:0] par;
    logic [POS_W-1:0]  last;

    always_comb begin
        t_ext = {1'b0, POS_W'(r_t)};
        l_ext = (t_ext << 1) + (POS_W+1)'(1);
        r_ext = l_ext + (POS_W+1)'(1);
        has_l = l_ext < {1'b0, r_size};
        has_r = r_ext < {1'b0, r_size};
        has_p = r_t != '0;
        par   = SLOT_W'((r_t - SLOT_W'(1)) >> 1);
        last  = r_size - POS_W'(1);
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        hm_we    = 1'b0;
        hm_waddr = r_t;
        hm_wkey  = r_tkey;
        hm_wid   = r_tid;
        hm_raddr = r_t;
        pm_we    = 1'b0;
        pm_waddr = r_tid;
        pm_wdata = POS_W'(r_t);
        pm_raddr = r_id;
        case (r_state)
            S_CLEAR: begin
                pm_we    = 1'b1;
                pm_waddr = r_clr;
                pm_wdata = ABSENT;
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                pm_raddr = i_item_id;
                if (i_valid) n_state = S_PRD;
            end
            S_PRD: n_state = S_DEC;
            S_DEC: begin
                // pm_rdata holds the id's position
                case (r_req)
                    REQ_UPSERT: begin
                        if (pm_rdata < r_size) begin
                            hm_we = 1'b1; hm_waddr = SLOT_W'(pm_rdata);
                            hm_wkey = r_key; hm_wid = r_id;
                            n_state = S_SIFT;
                        end else if (r_size >= ABSENT) begin
                            n_state = S_TOP;
                        end else begin
                            hm_we = 1'b1; hm_waddr = SLOT_W'(r_size);
                            hm_wkey = r_key; hm_wid = r_id;
                            pm_we = 1'b1; pm_waddr = r_id; pm_wdata = r_size;
                            n_state = S_SIFT;
                        end
                    end
                    REQ_REMOVE: n_state = (pm_rdata < r_size) ? S_RDX : S_TOP;
                    REQ_POP:    n_state = (r_size == '0) ? S_TOP : S_RDX;
                    REQ_QUERY:  n_state = (pm_rdata < r_size) ? S_RDX : S_TOP;
                    default:    n_state = S_TOP;
                endcase
            end
            S_RDX: begin
                hm_raddr = r_t;
                n_state = S_RDL;
            end
            S_RDL: begin
                hm_raddr = SLOT_W'(last);
                n_state = (r_req == REQ_QUERY) ? S_TOP : S_MOVE;
            end
            S_MOVE: begin
                // last entry into the vacated slot; the leaving id is marked absent in S_SWM
                hm_we = 1'b1; hm_waddr = r_t; hm_wkey = hm_rkey; hm_wid = hm_rid;
                pm_we = 1'b1; pm_waddr = hm_rid; pm_wdata = POS_W'(r_t);
                n_state = S_SWM;
            end
            S_SIFT: begin
                hm_raddr = r_t;
                n_state = S_SP;
            end
            S_SP: begin
                hm_raddr = par;
                n_state = S_SPC;
            end
            S_SPC: begin
                // hm_r* holds the parent when has_p
                if (has_p && r_tkey < hm_rkey) n_state = S_SWP;
                else if (has_l) begin
                    hm_raddr = SLOT_W'(l_ext);
                    n_state = S_SL;
                end else n_state = S_TOP;
            end
            S_SL: begin
                hm_raddr = SLOT_W'(r_ext);
                n_state = has_r ? S_SR : S_SCC;
            end
            S_SR: n_state = S_SCC;
            S_SCC: begin
                if (r_ckey < r_tkey) n_state = S_SWP;
                else n_state = S_TOP;
            end
            S_SWP: begin
                hm_we = 1'b1; hm_waddr = r_t; hm_wkey = r_ckey; hm_wid = r_cid;
                pm_we = 1'b1; pm_waddr = r_cid; pm_wdata = POS_W'(r_t);
                n_state = S_SWM;
            end
            S_SWM: begin
                if (r_rd_wait) begin
                    // after a remove/pop move: clear the leaving id's position
                    pm_we = 1'b1; pm_waddr = r_res_id; pm_wdata = ABSENT;
                    n_state = (r_t < SLOT_W'(r_size) && POS_W'(r_t) < r_size)
                              ? S_SIFT : S_TOP;
                end else begin
                    hm_we = 1'b1; hm_waddr = r_c; hm_wkey = r_tkey; hm_wid = r_tid;
                    pm_we = 1'b1; pm_waddr = r_tid; pm_wdata = POS_W'(r_c);
                    n_state = S_SIFT;
                end
            end
            S_TOP: begin
                hm_raddr = '0;
                n_state = S_OUT;
            end
            S_OUT: begin
                // Keep the top slot on the read port until the result is taken.
                hm_raddr = '0;
                if (!r_o_valid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_size  <= '0;
            r_clr   <= '0;
            r_rd_wait <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + ID_W'(1);
                S_IDLE: if (i_valid) begin
                    r_req <= i_req_type; r_id <= i_item_id;
                    r_key <= KEY_WIDTH'(i_item_key);
                    r_res_key <= '0; r_id_set <= 1'b0; r_status <= ST_OK;
                    r_rd_wait <= 1'b0;
                end
                S_DEC: begin
                    r_present <= (r_req == REQ_POP) ? (r_size != '0) : (pm_rdata < r_size);
                    case (r_req)
                        REQ_UPSERT: begin
                            if (pm_rdata < r_size) begin
                                r_t <= SLOT_W'(pm_rdata);
                                r_res_key <= 32'(r_key);
                            end else if (r_size >= ABSENT) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_t <= SLOT_W'(r_size);
                                r_size <= r_size + POS_W'(1);
                                r_res_key <= 32'(r_key);
                            end
                        end
                        REQ_POP: begin
                            r_t <= '0;
                            r_id_set <= 1'b1;
                            if (r_size == '0) begin
                                r_status <= ST_EMPTY;
                                r_res_id <= '0;
                            end
                        end
                        default: r_t <= SLOT_W'(pm_rdata);
                    endcase
                end
                S_RDL: begin
                    // target slot data arrives
                    r_res_key <= 32'(hm_rkey);
                    r_res_id  <= hm_rid;
                end
                S_MOVE: begin
                    // remove/pop: shrink and remember that a position clear follows
                    r_size <= last;
                    r_rd_wait <= 1'b1;
                    r_tkey <= hm_rkey; r_tid <= hm_rid;
                end
                S_SIFT: ;
                S_SP: begin
                    r_tkey <= hm_rkey; r_tid <= hm_rid;
                end
                S_SPC: begin
                    r_c <= par; r_ckey <= hm_rkey; r_cid <= hm_rid;
                end
                S_SL: begin
                    r_c <= SLOT_W'(l_ext); r_ckey <= hm_rkey; r_cid <= hm_rid;
                end
                S_SR: if (!(r_ckey < hm_rkey)) begin
                    // right child chosen on equal or smaller key
                    r_c <= SLOT_W'(r_ext); r_ckey <= hm_rkey; r_cid <= hm_rid;
                end
                S_SWM: begin
                    if (!r_rd_wait) r_t <= r_c;
                    r_rd_wait <= 1'b0;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_o_valid || i_ready)) begin
                r_o_valid <= 1'b1;
                r_o_rkey  <= r_res_key;
                r_o_rid   <= r_id_set ? r_res_id : (r_size != '0 ? hm_rid : '0);
                r_o_tkey  <= r_size != '0 ? 32'(hm_rkey) : '0;
                r_o_pres  <= r_present;
                r_o_cnt   <= 9'(r_size);
                r_o_st    <= r_status;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_result_key  = r_o_rkey;
    assign o_result_id   = r_o_rid;
    assign o_top_key     = r_o_tkey;
    assign o_is_present  = r_o_pres;
    assign o_entry_count = r_o_cnt;
    assign o_status      = r_o_st;

endmodule

// ===== design/imh_heap_mem.sv =====
// ----------------------------------------------------------------------------
// imh_heap_mem: heap slot storage
// One memory holding key and id for each heap slot, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module imh_heap_mem
    import imh_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int SLOT_W    = $clog2(CAPACITY)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [SLOT_W-1:0]    i_waddr,
    input  logic [KEY_WIDTH-1:0] i_wkey,
    input  logic [ID_W-1:0]      i_wid,
    input  logic [SLOT_W-1:0]    i_raddr,
    output logic [KEY_WIDTH-1:0] o_rkey,
    output logic [ID_W-1:0]      o_rid
);

    logic [KEY_WIDTH+ID_W-1:0] r_mem [CAPACITY];
    logic [KEY_WIDTH+ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wkey, i_wid};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rkey = r_rdata[KEY_WIDTH+ID_W-1:ID_W];
    assign o_rid  = r_rdata[ID_W-1:0];

endmodule

// ===== design/imh_pos_mem.sv =====
// ----------------------------------------------------------------------------
// imh_pos_mem: id to slot position map
// One entry per id; after reset the unit's clearing pass marks every id absent.
// ----------------------------------------------------------------------------
module imh_pos_mem
    import imh_pkg::*;
#(
    parameter int POS_W = 9
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ID_W-1:0]  i_waddr,
    input  logic [POS_W-1:0] i_wdata,
    input  logic [ID_W-1:0]  i_raddr,
    output logic [POS_W-1:0] o_rdata
);

    logic [POS_W-1:0] r_mem [ID_COUNT];
    logic [POS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/imh_checker.sv =====
// ----------------------------------------------------------------------------
// imh_checker: port-level checks of the indexed min-heap unit
// Observes the handshake and result fields at the top level.
// ----------------------------------------------------------------------------
module imh_port_checks
    import imh_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_top_key,
    input logic [8:0]  o_entry_count,
    input logic [1:0]  o_status,
    input logic        o_is_present
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_entry_count) && $stable(o_top_key))
        else $error("result dropped");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_count == 9'd0 |-> o_top_key == 32'd0)
        else $error("empty heap with nonzero top");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> !o_is_present && o_entry_count == 9'd0)
        else $error("bad empty pop result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_EMPTY || o_status == ST_FULL))
        else $error("unknown status code");

endmodule

bind indexed_min_heap_unit imh_port_checks u_imh_port_checks (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid),
    .i_ready(i_ready), .o_top_key(o_top_key), .o_entry_count(o_entry_count),
    .o_status(o_status), .o_is_present(o_is_present)
);

// ===== sim/imh_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imh_checker: result predictor and scoreboard for the indexed min-heap unit
// Watches both channels, keeps its own copy of the heap and position map,
// and compares each delivered result field by field with the oldest
// expectation.
// ----------------------------------------------------------------------------
module imh_checker
    import imh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_item_id,
    input  logic [31:0] i_item_key,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_result_key,
    input  logic [7:0]  i_result_id,
    input  logic [31:0] i_top_key,
    input  logic        i_is_present,
    input  logic [8:0]  i_entry_count,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] result_key;
        logic [7:0]  result_id;
        logic [31:0] top_key;
        logic        is_present;
        logic [8:0]  entry_count;
        logic [1:0]  status;
    } heap_result_t;

    localparam int CAP = DEF_CAPACITY;

    logic [31:0] heap_keys [CAP];
    logic [7:0]  heap_ids  [CAP];
    int          slot_of   [ID_COUNT];
    int          heap_count;
    heap_result_t expected_results [$];

    assign o_pending = expected_results.size();

    function automatic void swap_slots(int a, int b);
        logic [31:0] k;
        logic [7:0]  v;
        k = heap_keys[a];
        v = heap_ids[a];
        heap_keys[a] = heap_keys[b];
        heap_ids[a] = heap_ids[b];
        heap_keys[b] = k;
        heap_ids[b] = v;
        slot_of[heap_ids[a]] = a;
        slot_of[heap_ids[b]] = b;
    endfunction

    // Moves one slot up or down until the heap order holds again; on equal
    // children the right one is taken.
    function automatic void restore_order(int t);
        int l, r, c;
        while (t < heap_count) begin
            l = 2 * t + 1;
            r = l + 1;
            if (t > 0 && heap_keys[t] < heap_keys[(t - 1) / 2]) begin
                swap_slots(t, (t - 1) / 2);
                t = (t - 1) / 2;
            end else if (l < heap_count) begin
                c = (r >= heap_count || heap_keys[l] < heap_keys[r]) ? l : r;
                if (heap_keys[c] < heap_keys[t]) begin
                    swap_slots(t, c);
                    t = c;
                end else begin
                    break;
                end
            end else begin
                break;
            end
        end
    endfunction

    function automatic heap_result_t apply_request(logic [1:0] req, logic [7:0] id,
                                                   logic [31:0] key);
        heap_result_t res;
        int  pos, last, n;
        logic present, id_set;
        logic [7:0] first;
        pos = slot_of[id];
        present = pos < heap_count;
        res = '0;
        res.is_present = present;
        id_set = 1'b0;
        case (req)
            REQ_UPSERT: begin
                if (present) begin
                    heap_keys[pos] = key;
                    restore_order(pos);
                    res.result_key = key;
                end else if (heap_count >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    n = heap_count;
                    heap_count++;
                    slot_of[id] = n;
                    heap_keys[n] = key;
                    heap_ids[n] = id;
                    restore_order(n);
                    res.result_key = key;
                end
            end
            REQ_REMOVE: begin
                if (present) begin
                    heap_count--;
                    last = heap_count;
                    res.result_key = heap_keys[pos];
                    swap_slots(last, pos);
                    if (pos < last) restore_order(pos);
                    slot_of[id] = CAP;
                end
            end
            REQ_POP: begin
                id_set = 1'b1;
                if (heap_count == 0) begin
                    res.status = ST_EMPTY;
                    res.is_present = 1'b0;
                end else begin
                    first = heap_ids[0];
                    heap_count--;
                    last = heap_count;
                    res.result_key = heap_keys[0];
                    res.result_id = first;
                    swap_slots(last, 0);
                    if (last > 0) restore_order(0);
                    slot_of[first] = CAP;
                    res.is_present = 1'b1;
                end
            end
            default: begin
                if (present) res.result_key = heap_keys[pos];
            end
        endcase
        if (!id_set) res.result_id = heap_count > 0 ? heap_ids[0] : 8'd0;
        res.top_key = heap_count > 0 ? heap_keys[0] : 32'd0;
        res.entry_count = heap_count[8:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        heap_result_t exp_res;
        if (!i_rst_n) begin
            o_fail_count = 0;
            heap_count = 0;
            for (int i = 0; i < ID_COUNT; i++) slot_of[i] = CAP;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_request(i_req_type, i_item_id, i_item_key));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result delivered with no item outstanding");
                    o_fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_result_key !== exp_res.result_key) begin
                        $error("result_key: expected %0h, got %0h", exp_res.result_key,
                               i_result_key);
                        o_fail_count++;
                    end
                    if (i_result_id !== exp_res.result_id) begin
                        $error("result_id: expected %0d, got %0d", exp_res.result_id,
                               i_result_id);
                        o_fail_count++;
                    end
                    if (i_top_key !== exp_res.top_key) begin
                        $error("top_key: expected %0h, got %0h", exp_res.top_key, i_top_key);
                        o_fail_count++;
                    end
                    if (i_is_present !== exp_res.is_present) begin
                        $error("is_present: expected %0d, got %0d", exp_res.is_present,
                               i_is_present);
                        o_fail_count++;
                    end
                    if (i_entry_count !== exp_res.entry_count) begin
                        $error("entry_count: expected %0d, got %0d", exp_res.entry_count,
                               i_entry_count);
                        o_fail_count++;
                    end
                    if (i_status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, i_status);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the indexed min-heap unit
// Drives directed and random heap requests with random idling on both
// channels, including filling the heap to capacity and popping from it.
// ----------------------------------------------------------------------------
module tb_top;
    import imh_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = REQ_QUERY;
    logic [7:0]  i_item_id = '0;
    logic [31:0] i_item_key = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result_key;
    logic [7:0]  o_result_id;
    logic [31:0] o_top_key;
    logic        o_is_present;
    logic [8:0]  o_entry_count;
    logic [1:0]  o_status;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 8;
    int          recv_idle_pct = 46;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    indexed_min_heap_unit DUT (.*);

    imh_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_req_type, .i_item_id, .i_item_key,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_result_key(o_result_key), .i_result_id(o_result_id),
        .i_top_key(o_top_key), .i_is_present(o_is_present),
        .i_entry_count(o_entry_count), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Keys mostly come from a narrow range so that equal keys are frequent.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(15);
        endcase
    endfunction

    // Valid stays high from one item to the next unless the sender idles.
    task automatic send_request(logic [1:0] req, logic [7:0] id, logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_item_id <= id;
        i_item_key <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        logic [1:0] req;
        for (int n = 0; n < count; n++) begin
            req = 2'($urandom_range(3));
            if ($urandom_range(1)) req = REQ_UPSERT;
            // Small id pool keeps hits on remove, query and re-key common.
            send_request(req, 8'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(31)),
                         pick_key());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(REQ_POP, 8'd0, 32'd0);
        send_request(REQ_QUERY, 8'd5, 32'd0);
        send_request(REQ_REMOVE, 8'd5, 32'd0);
        send_request(REQ_UPSERT, 8'd255, 32'hFFFF_FFFF);
        send_request(REQ_UPSERT, 8'd0, 32'd0);
        send_request(REQ_UPSERT, 8'd7, 32'd9);
        send_request(REQ_UPSERT, 8'd8, 32'd9);
        send_request(REQ_UPSERT, 8'd9, 32'd9);
        send_request(REQ_UPSERT, 8'd0, 32'd20);
        send_request(REQ_QUERY, 8'd255, 32'd0);
        send_request(REQ_UPSERT, 8'd255, 32'd1);
        send_request(REQ_REMOVE, 8'd7, 32'd0);
        send_request(REQ_POP, 8'd0, 32'd0);
        send_request(REQ_POP, 8'd0, 32'd0);
        send_request(REQ_REMOVE, 8'd0, 32'd0);
        send_request(REQ_POP, 8'd0, 32'd0);
        send_request(REQ_POP, 8'd0, 32'd0);
        wait_drained();

        random_phase(60);
        send_idle_pct = 46;
        recv_idle_pct = 8;
        // Fill to capacity, then re-key and remove in the full heap.
        for (int i = 0; i < 256; i++) send_request(REQ_UPSERT, i[7:0], pick_key());
        send_request(REQ_UPSERT, 8'd3, 32'd0);
        send_request(REQ_REMOVE, 8'd100, 32'd0);
        send_request(REQ_UPSERT, 8'd100, 32'd5);
        send_request(REQ_UPSERT, 8'd100, 32'hFFFF_FFFF);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 60; i++) send_request(REQ_POP, 8'($urandom()), $urandom());
        random_phase(60);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== indexed_min_heap_unit.f =====
design/imh_pkg.sv
design/imh_heap_mem.sv
design/imh_pos_mem.sv
design/indexed_min_heap_unit.sv
design/imh_checker.sv
sim/imh_checker.sv
sim/tb_top.sv
